FILE: hdl/five_channel_hold_debouncer_top_defines.svh
// assertion macros shared by the debouncer checker
`ifndef FIVE_CHANNEL_HOLD_DEBOUNCER_TOP_DEFINES_SVH
`define FIVE_CHANNEL_HOLD_DEBOUNCER_TOP_DEFINES_SVH

// checked only outside reset
`define FCHD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define FCHD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/fchd_pkg.sv
// types and constants of the hold debouncer
package fchd_pkg;

   localparam int COUNT_W      = 16;
   localparam int CHAN_W       = 3;
   localparam int PIN_CHANNELS = 5;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 8;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd6000;

   // bit positions of the pins inside req_tdata
   localparam int PIN_OUT_FEED      = 0;
   localparam int PIN_IN_FEED       = 1;
   localparam int PIN_CUTTER_A      = 2;
   localparam int PIN_CUTTER_B      = 3;
   localparam int PIN_PLATEN_REL    = 4;
   localparam int PIN_PLATEN_PRESS  = 5;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_RELEASE = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      event_kind_type    kind;
   } event_type;

endpackage

FILE: hdl/fchd_lane.sv
// one channel: hold counter and its press / release detection
module fchd_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fchd_pkg::COUNT_W-1:0] limit,
   input  logic [fchd_pkg::COUNT_W-1:0] near_limit,
   input  logic                        pressed,
   input  logic                        commit,
   output fchd_pkg::event_kind_type    kind
);
   import fchd_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_next;

   always_comb begin
      count_next = count_ff;
      kind       = KIND_NONE;
      if (pressed) begin
         if (count_ff < limit) begin
            count_next = count_ff + 1'b1;
            if (count_next == near_limit) begin
               kind = KIND_PRESS;
            end
         end
      end else begin
         if (count_ff >= limit) begin
            kind = KIND_RELEASE;
         end
         count_next = '0;
      end
   end

   assign count_in = commit ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/fchd_merge.sv
// priority merge: first lane with an event wins, later lanes hold
module fchd_merge #(
   parameter int CHANNELS = 5
) (
   input  fchd_pkg::event_kind_type kinds [CHANNELS],
   output logic [CHANNELS-1:0]      commit,
   output fchd_pkg::event_type      evt
);
   import fchd_pkg::*;

   logic found;

   always_comb begin
      found       = 1'b0;
      evt.channel = '0;
      evt.kind    = KIND_NONE;
      for (int i = 0; i < CHANNELS; i++) begin
         commit[i] = !found;
         if (!found && kinds[i] != KIND_NONE) begin
            found       = 1'b1;
            evt.channel = CHAN_W'(i);
            evt.kind    = kinds[i];
         end
      end
   end

endmodule

FILE: hdl/five_channel_hold_debouncer_top.sv
// hold debouncer top level: pin decode, channel lanes, merge, output register
//
//   channel  dir  payload
//   req      in   tdata[5:0] switch pins, one word per sampling tick
//   rsp      out  tdata[2:0] event channel, tuser[1:0] event kind
//   csr      in   wdata[15:0] hold limit
//
// one word per cycle while req_tready is high; lanes and merge decide combinationally
// each result lands in the output register in the cycle after its word is accepted
// reset clears all hold counters, empties the output register, hold limit goes to 6000
// req_tready is high while the output register is empty or being read
module five_channel_hold_debouncer_top #(
   parameter int CHANNELS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // out_feed, in_feed, cutter_a, cutter_b, platen_release, platen_press, 2 zero bits
   input  logic [fchd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_channel, 5 zero bits
   output logic [fchd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // event_kind
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [fchd_pkg::COUNT_W-1:0] csr_wdata
);
   import fchd_pkg::*;

   logic [COUNT_W-1:0]      limit_ff;
   logic [COUNT_W-1:0]      limit_in;
   logic [COUNT_W-1:0]      near_limit;
   logic [PIN_CHANNELS-1:0] pin_pressed;
   logic [CHANNELS-1:0]     pressed;
   logic [CHANNELS-1:0]     commit;
   event_kind_type          kinds [CHANNELS];
   event_type               evt;
   logic                    req_accept;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   event_type               rsp_evt_ff;
   event_type               rsp_evt_in;

   assign csr_ready  = 1'b1;
   assign limit_in   = (csr_valid && csr_ready) ? csr_wdata : limit_ff;
   assign near_limit = limit_ff - 1'b1;

   // pins are active low, the cutter needs both buttons
   assign pin_pressed[0] = !req_tdata[PIN_OUT_FEED];
   assign pin_pressed[1] = !req_tdata[PIN_IN_FEED];
   assign pin_pressed[2] = !req_tdata[PIN_CUTTER_A] && !req_tdata[PIN_CUTTER_B];
   assign pin_pressed[3] = !req_tdata[PIN_PLATEN_REL];
   assign pin_pressed[4] = !req_tdata[PIN_PLATEN_PRESS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      if (i < PIN_CHANNELS) begin : g_pin
         assign pressed[i] = pin_pressed[i];
      end else begin : g_nopin
         assign pressed[i] = 1'b0;
      end

      fchd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .limit      (limit_ff),
         .near_limit (near_limit),
         .pressed    (pressed[i]),
         .commit     (req_accept && commit[i]),
         .kind       (kinds[i])
      );
   end

   fchd_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .kinds  (kinds),
      .commit (commit),
      .evt    (evt)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   assign rsp_evt_in   = req_accept ? evt : rsp_evt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_evt_ff <= rsp_evt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CHAN_W){1'b0}}, rsp_evt_ff.channel};
   assign rsp_tuser  = rsp_evt_ff.kind;

endmodule

FILE: hdl/fchd_checker.sv
// port-level checks of the hold debouncer, bound to the top level
`include "five_channel_hold_debouncer_top_defines.svh"

module fchd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic       shape_ok;
   logic       rsp_stall;
   logic [9:0] rsp_word;

   assign shape_ok  = (rsp_tuser != 2'd0 || rsp_tdata[2:0] == 3'd0) &&
                      rsp_tdata[7:3] == 5'd0 && rsp_tuser != 2'd3;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tdata, rsp_tuser};

   // output register empties on reset
   `FCHD_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

   // every accepted word yields a result on the next cycle
   `FCHD_ASSERT(a_word_result, (req_tvalid && req_tready) |=> rsp_tvalid, "accepted word lost")

   // no-event results carry channel zero, padding stays zero, kind is legal
   `FCHD_ASSERT(a_rsp_shape, rsp_tvalid |-> shape_ok, "bad result word")

   // stalled result holds
   `FCHD_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_tvalid && $stable(rsp_word)), "stall broken")

endmodule

bind five_channel_hold_debouncer_top fchd_checker u_fchd_checker (.*);

FILE: tb/sv/tb_five_channel_hold_debouncer_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the five channel hold debouncer top level
module tb_five_channel_hold_debouncer_top;
   import fchd_pkg::*;

   localparam int CHANNELS = 5;
   localparam int CYCLE_LIMIT = 100_000;
   localparam logic [5:0] ALL_RELEASED = 6'h3F;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = {2'b00, ALL_RELEASED};
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_wdata = '0;

   // behavioral copy of the block state
   logic [COUNT_W-1:0] hold_count [CHANNELS] = '{default: '0};
   logic [COUNT_W-1:0] hold_limit = LIMIT_RESET;
   event_type pending_events [$];

   int mismatch_count = 0;
   int tick_count = 0;
   int press_count = 0;
   int release_count = 0;
   int limit_writes = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_run = 0;

   five_channel_hold_debouncer_top #(.CHANNELS(CHANNELS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_events.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // serves channels in order; the first event ends the tick
   function automatic event_type predict_event(input logic [5:0] pins);
      logic pressed [PIN_CHANNELS];
      logic [COUNT_W-1:0] near_limit;
      logic [COUNT_W-1:0] count;
      logic held;
      event_type ev;
      near_limit = hold_limit - 1'b1;
      pressed[0] = !pins[PIN_OUT_FEED];
      pressed[1] = !pins[PIN_IN_FEED];
      pressed[2] = !pins[PIN_CUTTER_A] && !pins[PIN_CUTTER_B];
      pressed[3] = !pins[PIN_PLATEN_REL];
      pressed[4] = !pins[PIN_PLATEN_PRESS];
      ev.channel = '0;
      ev.kind = KIND_NONE;
      for (int i = 0; i < CHANNELS && ev.kind == KIND_NONE; i++) begin
         held = (i < PIN_CHANNELS) ? pressed[i] : 1'b0;
         count = hold_count[i];
         if (held) begin
            if (count < hold_limit) begin
               count = count + 1'b1;
               hold_count[i] = count;
               if (count == near_limit) begin
                  ev.kind = KIND_PRESS;
                  ev.channel = CHAN_W'(i);
               end
            end
         end else begin
            if (count >= hold_limit) begin
               ev.kind = KIND_RELEASE;
               ev.channel = CHAN_W'(i);
            end
            hold_count[i] = '0;
         end
      end
      return ev;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("mismatch on result after tick %0d: %s expected %0h got %0h",
               tick_count, what, want, got);
      mismatch_count++;
   endtask

   // one sampling tick; the sender runs in bursts with random gaps between them
   task automatic send_tick(input logic [5:0] pins);
      int gap;
      event_type ev;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pins};
      do @(posedge clock); while (!req_tready);
      ev = predict_event(pins);
      pending_events.push_back(ev);
      tick_count++;
      if (ev.kind == KIND_PRESS)
         press_count++;
      if (ev.kind == KIND_RELEASE)
         release_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_hold_limit(input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      hold_limit = value;
      limit_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: runs of always ready, random stalls, and a periodic stall
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run = $urandom_range(8, 60);
      end
      stall_run = stall_run - 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (cycle_count % 5 != 0);
      endcase
   end

   always @(posedge clock) begin : result_check
      event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            report_mismatch("result with nothing pending, kind", 8'h00, 8'(rsp_tuser));
         end else begin
            want = pending_events.pop_front();
            if (rsp_tdata[CHAN_W-1:0] !== want.channel)
               report_mismatch("event channel", 8'(want.channel), 8'(rsp_tdata[CHAN_W-1:0]));
            if (rsp_tuser !== want.kind)
               report_mismatch("event kind", 8'(want.kind), 8'(rsp_tuser));
         end
      end
   end

   // reset limit: out feed held well short of the press point, then released quietly
   task automatic test_reset_limit();
      logic [5:0] pins;
      repeat (40) begin
         pins = 6'($urandom);
         pins[PIN_OUT_FEED] = 1'b0;
         send_tick(pins);
      end
      send_tick(ALL_RELEASED);
   endtask

   // every channel at the smallest limit, priority order, half-pressed cutter
   task automatic test_channel_priority();
      wait_idle();
      write_hold_limit(16'd2);
      send_tick(ALL_RELEASED);
      send_tick(6'h3B);
      send_tick(6'h37);
      send_tick(6'h3B);
      // all pressed: one press word per channel in order, then nothing
      repeat (6) send_tick(6'h00);
      // all released: one release word per channel in order, then nothing
      repeat (6) send_tick(ALL_RELEASED);
   endtask

   // limit lowered under a hold, and a release before the press point
   task automatic test_limit_lowered();
      wait_idle();
      write_hold_limit(16'd10);
      repeat (5) send_tick(6'h3D);
      wait_idle();
      write_hold_limit(16'd3);
      repeat (2) send_tick(6'h3D);
      send_tick(ALL_RELEASED);
      wait_idle();
      write_hold_limit(16'd4);
      repeat (2) send_tick(6'h1F);
      send_tick(ALL_RELEASED);
   endtask

   // switch levels that mostly stay put, with some fully random ticks
   task automatic test_random_holds();
      logic [5:0] levels;
      int flip_odds;
      levels = ALL_RELEASED;
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: write_hold_limit(16'd2);
            1: write_hold_limit(16'd3);
            5: write_hold_limit(COUNT_W'($urandom_range(20, 40)));
            default: write_hold_limit(COUNT_W'($urandom_range(2, 12)));
         endcase
         flip_odds = $urandom_range(3, 12);
         repeat (200) begin
            if ($urandom_range(0, 9) == 0) begin
               send_tick(6'($urandom));
            end else begin
               for (int b = 0; b < 6; b++)
                  if ($urandom_range(1, flip_odds) == 1)
                     levels[b] = ~levels[b];
               // keep the two cutter pins together now and then
               if ($urandom_range(0, 1) == 1)
                  levels[PIN_CUTTER_B] = levels[PIN_CUTTER_A];
               send_tick(levels);
            end
         end
      end
   endtask

   // largest limit: platen press held while the other pins chatter, no event expected
   task automatic test_max_limit();
      logic [5:0] pins;
      wait_idle();
      write_hold_limit(16'hFFFF);
      repeat (60) begin
         pins = 6'($urandom);
         pins[PIN_PLATEN_PRESS] = 1'b0;
         send_tick(pins);
      end
      send_tick(ALL_RELEASED);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_limit();
      test_channel_priority();
      test_limit_lowered();
      test_random_holds();
      test_max_limit();
      wait_idle();
      repeat (4) @(posedge clock);
      $display("checked %0d ticks under %0d hold limit writes", tick_count, limit_writes);
      $display("saw %0d press and %0d release events", press_count, release_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
